/* hw/rtl/tfb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfb_pkg
// Shared types and constants of the telemetry frame builder.
// ----------------------------------------------------------------------------
package tfb_pkg;

	localparam logic [7:0] SYNC_BYTE  = 8'hAA;
	localparam logic [7:0] DEST_RESET = 8'hFF;
	localparam int unsigned QUEUE_DEPTH = 2;

	// one classified input word, handed from front to back
	typedef struct packed {
		logic       opens;
		logic       closes;
		logic [7:0] dest;
		logic [7:0] fc;
		logic [7:0] len;
		logic [7:0] data;
	} tfb_entry_t;

	// position of the back end within the current entry
	typedef enum logic [2:0] {
		PH_START,
		PH_DEST,
		PH_FC,
		PH_LEN,
		PH_DATA,
		PH_SUM,
		PH_ADD
	} tfb_phase_t;

endpackage
`default_nettype wire

/* hw/rtl/telemetry_frame_builder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// telemetry_frame_builder
// Frames a payload byte stream with header and sum checks.
// ----------------------------------------------------------------------------
// Each input word carries one payload byte; the word that opens a frame also
// carries the function code and payload length (zero counts as one). The
// block emits sync 0xAA, dest_address, function code and length ahead of the
// first payload byte, passes later payload bytes through, and closes the frame
// with the sum check and the additional check byte (frame_end set). run_last
// marks the last byte caused by each input word. The back end emits one byte
// per cycle unless out_stall is set: a payload word inside a frame gives one
// byte, a word opening a frame five, a word closing it three, a one-byte frame
// seven; a two-entry queue lets the front keep accepting while the back works.
// dest_address is written through cfg_we/cfg_wdata and resets to 0xFF.
module telemetry_frame_builder import tfb_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] function_code,
	input  wire logic [7:0] payload_length,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            frame_end,
	output logic            run_last
);

	tfb_entry_t push_entry;
	tfb_entry_t head;
	logic       push;
	logic       pop;
	logic       full;
	logic       empty;

	tfb_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.function_code  (function_code),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.q_full         (full),
		.q_push         (push),
		.q_entry        (push_entry)
	);

	tfb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.empty      (empty),
		.head       (head)
	);

	tfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (empty),
		.q_head    (head),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.frame_end (frame_end),
		.run_last  (run_last)
	);

endmodule
`default_nettype wire

/* hw/rtl/tfb_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfb_front
// Accepts input words, tracks frame boundaries and classifies each word.
// ----------------------------------------------------------------------------
module tfb_front import tfb_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] function_code,
	input  wire logic [7:0] payload_length,
	input  wire logic [7:0] data_byte,
	input  wire logic       q_full,
	output logic            q_push,
	output tfb_entry_t      q_entry
);

	logic       open_q;
	logic [7:0] left_q;
	logic [7:0] dest_q;
	logic [7:0] len_eff;
	logic       closes;

	// treat a zero length as one
	assign len_eff  = (payload_length == 8'd0) ? 8'd1 : payload_length;
	assign closes   = open_q ? (left_q == 8'd1) : (len_eff == 8'd1);
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// build the queue entry
	always_comb begin
		q_entry.opens  = !open_q;
		q_entry.closes = closes;
		q_entry.dest   = dest_q;
		q_entry.fc     = function_code;
		q_entry.len    = len_eff;
		q_entry.data   = data_byte;
	end

	// hold the destination address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_q <= DEST_RESET;
		end else if (cfg_we) begin
			dest_q <= cfg_wdata;
		end
	end

	// advance frame tracking on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			left_q <= 8'd0;
		end else if (q_push) begin
			open_q <= !closes;
			if (!open_q) begin
				left_q <= len_eff - 8'd1;
			end else begin
				left_q <= left_q - 8'd1;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/tfb_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfb_queue
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
module tfb_queue import tfb_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  tfb_entry_t push_entry,
	output logic       full,
	input  wire logic  pop,
	output logic       empty,
	output tfb_entry_t head
);

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);

	tfb_entry_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0]       wr_q;
	logic [PW-1:0]       rd_q;
	logic [PW:0]         cnt_q;

	assign full  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (PW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (PW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/tfb_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfb_back
// Serializes queued words into frame bytes and runs the two check sums.
// ----------------------------------------------------------------------------
module tfb_back import tfb_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_empty,
	input  tfb_entry_t q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  wire logic  out_stall,
	output logic [7:0] out_byte,
	output logic       frame_end,
	output logic       run_last
);

	tfb_phase_t phase_q;
	tfb_phase_t phase_nx;
	tfb_phase_t cur_ph;
	logic       load;
	logic       is_sync;
	logic       checked;
	logic       done;
	logic [7:0] byte_nx;
	logic       end_nx;
	logic [7:0] sum_q;
	logic [7:0] add_q;
	logic [7:0] sum_nx;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       frame_end_q;
	logic       run_last_q;

	assign load  = !q_empty && (!out_valid_q || !out_stall);
	assign q_pop = load && done;

	// next state
	always_comb begin
		phase_nx = phase_q;
		if (load) begin
			case (cur_ph)
				PH_START: phase_nx = PH_DEST;
				PH_DEST:  phase_nx = PH_FC;
				PH_FC:    phase_nx = PH_LEN;
				PH_LEN:   phase_nx = PH_DATA;
				PH_DATA:  phase_nx = q_head.closes ? PH_SUM : PH_START;
				PH_SUM:   phase_nx = PH_ADD;
				PH_ADD:   phase_nx = PH_START;
				default:  phase_nx = PH_START;
			endcase
		end
	end

	// outputs of the current position
	always_comb begin
		// a word that does not open a frame starts at its payload byte
		cur_ph  = (phase_q == PH_START && !q_head.opens) ? PH_DATA : phase_q;
		is_sync = 1'b0;
		checked = 1'b1;
		done    = 1'b0;
		end_nx  = 1'b0;
		case (cur_ph)
			PH_START: begin
				byte_nx = SYNC_BYTE;
				is_sync = 1'b1;
			end
			PH_DEST:  byte_nx = q_head.dest;
			PH_FC:    byte_nx = q_head.fc;
			PH_LEN:   byte_nx = q_head.len;
			PH_DATA: begin
				byte_nx = q_head.data;
				done    = !q_head.closes;
			end
			PH_SUM: begin
				byte_nx = sum_q;
				checked = 1'b0;
			end
			PH_ADD: begin
				byte_nx = add_q;
				checked = 1'b0;
				done    = 1'b1;
				end_nx  = 1'b1;
			end
			default: byte_nx = '0;
		endcase
	end

	// running sums restart at the sync byte
	assign sum_nx = is_sync ? byte_nx : sum_q + byte_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			sum_q   <= '0;
			add_q   <= '0;
		end else begin
			phase_q <= phase_nx;
			if (load && checked) begin
				sum_q <= sum_nx;
				add_q <= is_sync ? sum_nx : add_q + sum_nx;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= byte_nx;
			frame_end_q <= end_nx;
			run_last_q  <= done;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;
	assign run_last  = run_last_q;

endmodule
`default_nettype wire

/* hw/rtl/tfb_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tfb_checker
// Port-level checks of the telemetry frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module tfb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] function_code,
	input wire logic [7:0] payload_length,
	input wire logic [7:0] data_byte,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       frame_end,
	input wire logic       run_last
);

	// a stalled input word holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(function_code)
			&& $stable(payload_length) && $stable(data_byte))
		else $error("stalled input word changed");

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte)
			&& $stable(frame_end) && $stable(run_last))
		else $error("stalled output word changed");

	// the closing check byte is always the last byte of its input word
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_last)
		else $error("frame_end without run_last");

	// nothing is shown in the first cycle after reset
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("output valid straight out of reset");

	// a closing check byte is never followed at once by another one
	a_end_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && frame_end |=> !(out_valid && frame_end))
		else $error("back-to-back frame_end bytes");

endmodule

bind telemetry_frame_builder tfb_checker u_tfb_checker (.*);
`default_nettype wire
